// ===== sv/stt_pkg.sv =====
package stt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int TAG_W    = 16;
	localparam int TIME_W   = 32;
	localparam int MODE_W   = 2;
	localparam int TICK_W   = 24;
	localparam int STATUS_W = 2;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 24;

	localparam logic [TICK_W-1:0] TICK_RESET = 24'd1000;

	localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_MODE = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic {
		KIND_ADD  = 1'b0,
		KIND_TICK = 1'b1
	} in_kind_t;

	typedef enum logic {
		RES_STATUS = 1'b0,
		RES_FIRED  = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] remaining;
		logic              periodic;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// commands from controller to datapath
	typedef struct packed {
		logic in_take;
		logic add_go;
		logic tick_start;
		logic tick_step;
		logic tick_commit;
		logic flush_go;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic walk_done;
		logic fire_block;
		logic pend_valid;
	} dp_stat_t;

endpackage

// ===== sv/stt_ctrl.sv =====
module stt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  stt_pkg::dp_stat_t stat,
	output stt_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_TICK,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_take = s_tvalid && ready_q;
				if (cmd.in_take) begin
					if (s_tuser == stt_pkg::KIND_TICK) begin
						cmd.tick_start = 1'b1;
						state_d        = S_TICK;
					end else begin
						state_d = S_ADD;
					end
				end
			end
			S_ADD: begin
				if (stat.out_free) begin
					cmd.add_go = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_TICK: begin
				if (stat.walk_done) begin
					cmd.tick_commit = 1'b1;
					state_d         = S_FLUSH;
				end else begin
					cmd.tick_step = !stat.fire_block;
				end
			end
			S_FLUSH: begin
				// last fired word of the tick carries tlast
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush_go = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign s_tready = ready_q;

endmodule

// ===== sv/stt_dp.sv =====
module stt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stt_pkg::ctrl_cmd_t            cmd,
	output stt_pkg::dp_stat_t             stat,
	input  logic [stt_pkg::TAG_W-1:0]     in_tag,
	input  logic [stt_pkg::TIME_W-1:0]    in_timeout,
	input  logic [stt_pkg::MODE_W-1:0]    in_mode,
	input  logic                          cfg_we,
	input  logic [stt_pkg::TICK_W-1:0]    cfg_wdata,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_kind,
	output logic [stt_pkg::TAG_W-1:0]     out_tag,
	output logic [stt_pkg::STATUS_W-1:0]  out_status,
	output logic                          out_last
);

	stt_pkg::entry_t mem_q [stt_pkg::TABLE_DEPTH];
	stt_pkg::entry_t rd_data_q;
	logic            rd_valid_s1;

	logic [stt_pkg::CNT_W-1:0] count_q;
	logic [stt_pkg::CNT_W-1:0] rd_ptr_q;
	logic [stt_pkg::CNT_W-1:0] wr_ptr_q;

	logic [stt_pkg::TAG_W-1:0]  tag_q;
	logic [stt_pkg::TIME_W-1:0] timeout_q;
	logic [stt_pkg::MODE_W-1:0] mode_q;
	logic [stt_pkg::TICK_W-1:0] tick_q;

	logic                      pend_valid_q;
	logic [stt_pkg::TAG_W-1:0] pend_tag_q;

	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [stt_pkg::TAG_W-1:0]    out_tag_q;
	logic [stt_pkg::STATUS_W-1:0] out_status_q;
	logic                         out_last_q;

	logic                      out_free;
	logic                      fire;
	logic                      keep;
	logic [stt_pkg::TIME_W:0]  diff;
	logic [stt_pkg::TIME_W-1:0] dec_rem;
	stt_pkg::entry_t           wb_entry;
	stt_pkg::entry_t           add_entry;
	stt_pkg::status_t          add_status;
	logic                      add_write;
	logic                      tick_write;
	logic                      emit_pend;
	logic                      rd_en;
	logic                      wr_en;
	logic [stt_pkg::IDX_W-1:0] wr_addr;
	stt_pkg::entry_t           wr_data;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = rd_valid_s1 && (rd_data_q.remaining == '0);
	assign keep     = !fire || rd_data_q.periodic;

	// saturating countdown: a borrow means the entry reached zero
	assign diff    = (stt_pkg::TIME_W + 1)'(rd_data_q.remaining)
	               - (stt_pkg::TIME_W + 1)'(tick_q);
	assign dec_rem = diff[stt_pkg::TIME_W] ? '0 : diff[stt_pkg::TIME_W-1:0];

	always_comb begin
		wb_entry           = rd_data_q;
		wb_entry.remaining = dec_rem;
		add_entry.remaining = timeout_q;
		add_entry.periodic  = (mode_q == stt_pkg::MODE_PERIODIC);
		add_entry.tag       = tag_q;
	end

	always_comb begin
		if (mode_q != stt_pkg::MODE_ONESHOT && mode_q != stt_pkg::MODE_PERIODIC) begin
			add_status = stt_pkg::ST_BAD_MODE;
		end else if (count_q == stt_pkg::CNT_W'(stt_pkg::TABLE_DEPTH)) begin
			add_status = stt_pkg::ST_FULL;
		end else begin
			add_status = stt_pkg::ST_OK;
		end
	end

	assign add_write  = cmd.add_go && (add_status == stt_pkg::ST_OK);
	assign tick_write = cmd.tick_step && rd_valid_s1 && keep;
	assign emit_pend  = cmd.tick_step && fire && pend_valid_q;
	assign rd_en      = cmd.tick_step && (rd_ptr_q != count_q);
	assign wr_en      = add_write || tick_write;
	assign wr_addr    = add_write ? count_q[stt_pkg::IDX_W-1:0]
	                              : wr_ptr_q[stt_pkg::IDX_W-1:0];
	assign wr_data    = add_write ? add_entry : wb_entry;

	// the write pointer never passes the read pointer, so compaction is in place
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_ptr_q[stt_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			tag_q     <= in_tag;
			timeout_q <= in_timeout;
			mode_q    <= in_mode;
		end
		if (cmd.tick_step && fire) begin
			pend_tag_q <= rd_data_q.tag;
		end
		if (cmd.add_go) begin
			out_kind_q   <= stt_pkg::RES_STATUS;
			out_tag_q    <= '0;
			out_status_q <= add_status;
			out_last_q   <= 1'b1;
		end else if (emit_pend || cmd.flush_go) begin
			out_kind_q   <= stt_pkg::RES_FIRED;
			out_tag_q    <= pend_tag_q;
			out_status_q <= stt_pkg::ST_OK;
			out_last_q   <= cmd.flush_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= stt_pkg::TICK_RESET;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			rd_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end
			if (add_write) begin
				count_q <= count_q + stt_pkg::CNT_W'(1);
			end else if (cmd.tick_commit) begin
				count_q <= wr_ptr_q;
			end
			if (cmd.tick_start) begin
				rd_ptr_q    <= '0;
				wr_ptr_q    <= '0;
				rd_valid_s1 <= 1'b0;
			end else if (cmd.tick_step) begin
				if (rd_en) begin
					rd_ptr_q <= rd_ptr_q + stt_pkg::CNT_W'(1);
				end
				if (tick_write) begin
					wr_ptr_q <= wr_ptr_q + stt_pkg::CNT_W'(1);
				end
				rd_valid_s1 <= rd_en;
			end
			if (cmd.tick_start || cmd.flush_go) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.tick_step && fire) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.add_go || emit_pend || cmd.flush_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.out_free   = out_free;
		stat.walk_done  = (rd_ptr_q == count_q) && !rd_valid_s1;
		stat.fire_block = fire && pend_valid_q && !out_free;
		stat.pend_valid = pend_valid_q;
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_tag    = out_tag_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

// ===== sv/software_timer_table.sv =====
// software timer table
// input stream (s_*): tuser is the kind (0 add entry, 1 tick); tdata carries the
// tag, the timeout in ms and the mode (0 one-shot, 1 periodic) of an add.
// output stream (m_*): tuser 0 is an add status word (0 ok, 1 bad mode,
// 2 table full), tuser 1 is a fired entry with its tag; tlast marks the final
// word caused by one input word. a tick with nothing at zero gives no word.
// cfg_we/cfg_wdata load the tick interval in ms; the user must load it only while
// idle, as the block itself does not enforce it. an add waits in its own state for
// a free output register and then loads its status word there. a tick walks the
// entries once through the table memory (16 deep), one read and one compacting
// write-back per cycle while no fired entry is held back by the output, then
// commits the new count and, if a fired tag is held, passes it out with tlast. one word at a
// time is worked on; s_tready drops from acceptance until the work is done.
// when m_tready is low the walk pauses on the next fired entry, since one
// fired tag waits in a holding register until the following one shows
// whether it gets tlast. reset empties the table and sets the interval to
// 1000 ms; the entry storage itself is not cleared.
module software_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // task_tag[15:0], timeout_ms[47:16], mode[49:48], zero pad
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // fired_tag[15:0], status[17:16], zero pad
	output logic        m_tuser,  // result_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	stt_pkg::ctrl_cmd_t cmd;
	stt_pkg::dp_stat_t  stat;

	logic [stt_pkg::TAG_W-1:0]    out_tag;
	logic [stt_pkg::STATUS_W-1:0] out_status;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tag     (s_tdata[15:0]),
		.in_timeout (s_tdata[47:16]),
		.in_mode    (s_tdata[49:48]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (m_tuser),
		.out_tag    (out_tag),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'd0, out_status, out_tag};

endmodule

// ===== sv/stt_checker.sv =====
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// the block is busy right after it takes an add
	a_busy_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("input taken again right after an add");

	// a status word ends its item and carries no tag
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[15:0] == 16'd0))
		else $error("bad status word");

	// fired words carry status ok
	a_fired_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[17:16] == 2'd0))
		else $error("fired word with nonzero status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:16] != 2'd3) && (m_tdata[23:18] == 6'd0))
		else $error("undefined status code or pad bits set");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

// ===== bench/software_timer_table_tb.sv =====
`timescale 1ns / 1ps

module software_timer_table_tb;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 75;

	// modes that the block rejects
	localparam logic [stt_pkg::MODE_W-1:0] MODE_BAD_2 = 2'd2;
	localparam logic [stt_pkg::MODE_W-1:0] MODE_BAD_3 = 2'd3;

	typedef struct packed {
		stt_pkg::res_kind_t        kind;
		logic [stt_pkg::TAG_W-1:0] tag;
		stt_pkg::status_t          status;
		logic                      last;
	} out_word_t;

	typedef struct packed {
		stt_pkg::in_kind_t          kind;
		logic [stt_pkg::TAG_W-1:0]  tag;
		logic [stt_pkg::TIME_W-1:0] timeout;
		logic [stt_pkg::MODE_W-1:0] mode;
		logic                       fixed_exp;
		stt_pkg::status_t           fixed_status;
	} stim_row_t;

	// reset interval of 1000 ms holds through this part
	localparam stim_row_t STIM_ROWS [25] = '{
		'{stt_pkg::KIND_TICK, 16'hBEEF, 32'hFFFF_FFFF, MODE_BAD_3, 1'b0, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h0000, 32'h0000_0000, stt_pkg::MODE_ONESHOT, 1'b1,
			stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, stt_pkg::MODE_PERIODIC, 1'b1,
			stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1234, 32'h0000_0000, MODE_BAD_2, 1'b1,
			stt_pkg::ST_BAD_MODE},
		'{stt_pkg::KIND_ADD, 16'hA5A5, 32'd1000, stt_pkg::MODE_PERIODIC, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h5A5A, 32'd1500, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_TICK, 16'h0000, 32'h0000_0000, stt_pkg::MODE_ONESHOT, 1'b0,
			stt_pkg::ST_OK},
		'{stt_pkg::KIND_TICK, 16'h0000, 32'h0000_0000, stt_pkg::MODE_ONESHOT, 1'b0,
			stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1001, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1002, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1003, 32'd999, stt_pkg::MODE_PERIODIC, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1004, 32'd1000, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1005, 32'd1001, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1006, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1007, 32'd0, stt_pkg::MODE_PERIODIC, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1008, 32'h8000_0000, stt_pkg::MODE_ONESHOT, 1'b1,
			stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h1009, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h100A, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h100B, 32'd1, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h100C, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h100D, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_OK},
		'{stt_pkg::KIND_ADD, 16'h7777, 32'd0, stt_pkg::MODE_ONESHOT, 1'b1, stt_pkg::ST_FULL},
		'{stt_pkg::KIND_ADD, 16'h7777, 32'd0, MODE_BAD_3, 1'b1, stt_pkg::ST_BAD_MODE},
		'{stt_pkg::KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, MODE_BAD_3, 1'b0, stt_pkg::ST_OK},
		'{stt_pkg::KIND_TICK, 16'h0000, 32'h0000_0000, stt_pkg::MODE_ONESHOT, 1'b0,
			stt_pkg::ST_OK}
	};

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [stt_pkg::S_DATA_W-1:0] s_tdata   = '0;
	logic                         s_tuser   = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [stt_pkg::M_DATA_W-1:0] m_tdata;
	logic                         m_tuser;
	logic                         m_tlast;
	logic                         cfg_we    = 1'b0;
	logic [stt_pkg::TICK_W-1:0]   cfg_wdata = '0;

	// copy of the timer table as the block should hold it
	logic [stt_pkg::TIME_W-1:0] tbl_remaining [stt_pkg::TABLE_DEPTH];
	logic                       tbl_periodic  [stt_pkg::TABLE_DEPTH];
	logic [stt_pkg::TAG_W-1:0]  tbl_tag       [stt_pkg::TABLE_DEPTH];
	int                         tbl_count = 0;
	logic [stt_pkg::TICK_W-1:0] tick_ms   = stt_pkg::TICK_RESET;

	out_word_t step_words[$];
	out_word_t timer_words_due[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;

	logic [stt_pkg::TICK_W-1:0] phase_ms [PHASES];

	software_timer_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// add: one status word; tick: one word per entry at zero, fired one-shots drop out
	function automatic void table_step(input stt_pkg::in_kind_t kind,
			input logic [stt_pkg::TAG_W-1:0] tag,
			input logic [stt_pkg::TIME_W-1:0] timeout,
			input logic [stt_pkg::MODE_W-1:0] mode);
		int kept;
		logic [stt_pkg::TIME_W-1:0] rem;
		logic stays;
		out_word_t w;
		step_words.delete();
		if (kind == stt_pkg::KIND_ADD) begin
			w = '{stt_pkg::RES_STATUS, '0, stt_pkg::ST_OK, 1'b1};
			if (mode != stt_pkg::MODE_ONESHOT && mode != stt_pkg::MODE_PERIODIC) begin
				w.status = stt_pkg::ST_BAD_MODE;
			end else if (tbl_count >= stt_pkg::TABLE_DEPTH) begin
				w.status = stt_pkg::ST_FULL;
			end else begin
				tbl_remaining[tbl_count] = timeout;
				tbl_periodic[tbl_count]  = (mode == stt_pkg::MODE_PERIODIC);
				tbl_tag[tbl_count]       = tag;
				tbl_count++;
			end
			step_words = {step_words, w};
		end else begin
			kept = 0;
			for (int r = 0; r < tbl_count; r++) begin
				rem   = tbl_remaining[r];
				stays = 1'b1;
				if (rem == '0) begin
					w = '{stt_pkg::RES_FIRED, tbl_tag[r], stt_pkg::ST_OK, 1'b0};
					step_words = {step_words, w};
					stays = tbl_periodic[r];
				end else begin
					rem = (rem > tick_ms) ? rem - tick_ms : '0;
				end
				if (stays) begin
					tbl_remaining[kept] = rem;
					tbl_periodic[kept]  = tbl_periodic[r];
					tbl_tag[kept]       = tbl_tag[r];
					kept++;
				end
			end
			tbl_count = kept;
			if (step_words.size() != 0) begin
				w = step_words[$];
				w.last = 1'b1;
				step_words[$] = w;
			end
		end
	endfunction

	function automatic int periodic_entries();
		int n;
		n = 0;
		for (int i = 0; i < tbl_count; i++)
			if (tbl_periodic[i])
				n++;
		return n;
	endfunction

	// timeouts cluster around multiples of the interval to hit the saturation edge
	function automatic logic [stt_pkg::TIME_W-1:0] pick_timeout();
		longint unsigned t;
		int d;
		if (tick_ms == '0 && $urandom_range(0, 3) != 0)
			return '0;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom;
			default: begin
				t = longint'(tick_ms) * $urandom_range(0, 3);
				d = $urandom_range(0, 2);
				if (d == 0 && t > 0)
					t = t - 1;
				else if (d == 2)
					t = t + 1;
				if (t > 64'hFFFF_FFFF)
					t = 64'hFFFF_FFFF;
				return t[stt_pkg::TIME_W-1:0];
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what);
		$display("mismatch at %0d ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_word(input stt_pkg::in_kind_t kind,
			input logic [stt_pkg::TAG_W-1:0] tag,
			input logic [stt_pkg::TIME_W-1:0] timeout,
			input logic [stt_pkg::MODE_W-1:0] mode,
			input logic fixed_exp, input stt_pkg::status_t fixed_status);
		out_word_t w;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, mode, timeout, tag};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		table_step(kind, tag, timeout, mode);
		if (fixed_exp) begin
			w = '{stt_pkg::RES_STATUS, '0, fixed_status, 1'b1};
			timer_words_due = {timer_words_due, w};
		end else begin
			timer_words_due = {timer_words_due, step_words};
		end
	endtask

	task automatic random_word();
		logic [stt_pkg::MODE_W-1:0] mode;
		if ($urandom_range(0, 99) < 35) begin
			// tick: the data bits are junk the block must ignore
			send_word(stt_pkg::KIND_TICK, stt_pkg::TAG_W'($urandom), $urandom,
				stt_pkg::MODE_W'($urandom_range(0, 3)), 1'b0, stt_pkg::ST_OK);
		end else begin
			if ($urandom_range(0, 9) == 0)
				mode = $urandom_range(0, 1) ? MODE_BAD_3 : MODE_BAD_2;
			else if ($urandom_range(0, 7) == 0 && periodic_entries() < 10)
				mode = stt_pkg::MODE_PERIODIC;
			else
				mode = stt_pkg::MODE_ONESHOT;
			send_word(stt_pkg::KIND_ADD, stt_pkg::TAG_W'($urandom), pick_timeout(), mode,
				1'b0, stt_pkg::ST_OK);
		end
	endtask

	// a tick that fires nothing may still be walking when the last word is out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (timer_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(input logic [stt_pkg::TICK_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		tick_ms = value;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin : check_words
		out_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (timer_words_due.size() == 0) begin
				note_mismatch($sformatf("unexpected word kind %0d tag %h status %0d last %b",
					m_tuser, m_tdata[15:0], m_tdata[17:16], m_tlast));
			end else begin
				w = timer_words_due.pop_front();
				if (m_tuser !== w.kind || m_tdata[15:0] !== w.tag ||
						m_tdata[17:16] !== w.status || m_tlast !== w.last)
					note_mismatch($sformatf(
						"got kind %0d tag %h status %0d last %b, want %0d %h %0d %b",
						m_tuser, m_tdata[15:0], m_tdata[17:16], m_tlast,
						w.kind, w.tag, w.status, w.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		phase_ms[0] = 24'd1;
		phase_ms[1] = 24'hFF_FFFF;
		phase_ms[2] = 24'd0;
		phase_ms[3] = stt_pkg::TICK_W'($urandom_range(2, 24'hFF_FFFE));
		phase_ms[4] = 24'd1000;
		phase_ms[5] = stt_pkg::TICK_W'($urandom_range(1, 5000));

		tx_idle_pct = 36;
		rx_idle_pct = 86;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (STIM_ROWS[i])
			send_word(STIM_ROWS[i].kind, STIM_ROWS[i].tag, STIM_ROWS[i].timeout,
				STIM_ROWS[i].mode, STIM_ROWS[i].fixed_exp, STIM_ROWS[i].fixed_status);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_interval(phase_ms[p]);
			// receiver-heavy stalls, then sender-heavy, then none
			tx_idle_pct = (p < 2) ? 36 : (p < 4) ? 86 : 0;
			rx_idle_pct = (p < 2) ? 86 : (p < 4) ? 36 : 0;
			repeat (PHASE_WORDS) random_word();
		end
		settle();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
